>>> src/spring_tether_force_and_rate_unit_macros.svh
// assertion macros for the spring tether force and rate unit
`ifndef SPRING_TETHER_FORCE_AND_RATE_UNIT_MACROS_SVH
`define SPRING_TETHER_FORCE_AND_RATE_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication, checked out of reset
`define STFR_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication, checked out of reset
`define STFR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define STFR_ASSERT_IMPLY(lbl, ante, cons)
`define STFR_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> src/stfr_pkg.sv
// shared constants and types of the spring tether force and rate unit
package stfr_pkg;

	localparam int FRAC_BITS = 16;
	localparam int GAIN_W = 31;
	localparam logic [GAIN_W-1:0] RATE_GAIN = GAIN_W'(411775);

	localparam int MAG_W = 33;
	localparam int RAD_W = 2 * MAG_W;
	localparam int ROOT_W = 33;
	localparam int SQRT_STEPS = ROOT_W;
	localparam int REM_W = ROOT_W + 2;

	localparam int FDIV_STEPS = 32;
	localparam int FNUM_W = MAG_W + 32;

	localparam int RDIV_STEPS = 32 + FRAC_BITS;
	localparam int CLAMP_W = 31 + FRAC_BITS;
	localparam int LO_W = 24;
	localparam int HI_W = CLAMP_W - LO_W;
	localparam int PROD_W = CLAMP_W + GAIN_W;
	localparam int RATE_TAIL = 4;
	localparam int FORCE_DELAY = RDIV_STEPS + RATE_TAIL - FDIV_STEPS;

	localparam logic [31:0] FORCE_POS_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] FORCE_NEG_MAX = 32'h8000_0000;

	typedef enum logic [2:0] {
		CFG_ANCHOR_X       = 3'd0,
		CFG_ANCHOR_Y       = 3'd1,
		CFG_ANCHOR_Z       = 3'd2,
		CFG_STIFFNESS      = 3'd3,
		CFG_TENSION_TARGET = 3'd4,
		CFG_SLACK_OFFSET   = 3'd5,
		CFG_LENGTH_LIMIT   = 3'd6,
		CFG_RATE_LIMIT     = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [2:0][MAG_W-1:0] mag;
		logic [2:0]            neg;
		logic [31:0]           len;
		logic                  slack;
	} sqrt_side_t;

	typedef struct packed {
		logic [31:0] ten;
		logic        zero;
		logic [2:0]  neg;
	} fdiv_side_t;

endpackage

>>> src/spring_tether_force_and_rate_unit.sv
// top level of the spring tether force and rate unit
// pipeline depth: mostly the 33-step square root and the 48-step tension error divider,
//   each one stage per step, between the input request accept and out_valid
// throughput: one request per cycle, the pipeline stalls only when the output skid is full
// reset: arst_n clears all valid bits and loads the register reset values,
//   no clearing pass is needed
`include "spring_tether_force_and_rate_unit_macros.svh"

module spring_tether_force_and_rate_unit import stfr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	// configuration write port
	input  logic               cfg_wr_en,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	// input requests
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] end_x,
	input  logic signed [31:0] end_y,
	input  logic signed [31:0] end_z,
	input  logic [31:0]        line_length,
	input  logic               slack_mode,
	// result requests
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] force_x,
	output logic signed [31:0] force_y,
	output logic signed [31:0] force_z,
	output logic [31:0]        tension,
	output logic signed [31:0] length_rate
);

	typedef struct packed {
		logic [2:0][31:0] frc;
		logic [31:0]      ten;
		logic [31:0]      rate;
	} result_t;

	typedef struct packed {
		logic [2:0][31:0] frc;
		logic [31:0]      ten;
	} fout_t;

	typedef struct packed {
		logic [RDIV_STEPS-1:0] num;
		logic [31:0]           rem;
		logic [RDIV_STEPS-1:0] q;
		logic                  use_div;
		logic                  err_neg;
		logic [34:0]           byp_mag;
		logic                  byp_neg;
	} rdiv_stage_t;

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	logic [2:0][31:0] anchor_q;
	logic [31:0]      stiffness_q;
	logic [31:0]      tension_target_q;
	logic [31:0]      slack_offset_q;
	logic [31:0]      length_limit_q;
	logic [30:0]      rate_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			anchor_q         <= '0;
			stiffness_q      <= 32'd65536;
			tension_target_q <= '0;
			slack_offset_q   <= '0;
			length_limit_q   <= 32'hFFFF_FFFF;
			rate_limit_q     <= 31'd65536;
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				CFG_ANCHOR_X:       anchor_q[0]      <= cfg_data;
				CFG_ANCHOR_Y:       anchor_q[1]      <= cfg_data;
				CFG_ANCHOR_Z:       anchor_q[2]      <= cfg_data;
				CFG_STIFFNESS:      stiffness_q      <= cfg_data;
				CFG_TENSION_TARGET: tension_target_q <= cfg_data;
				CFG_SLACK_OFFSET:   slack_offset_q   <= cfg_data;
				CFG_LENGTH_LIMIT:   length_limit_q   <= cfg_data;
				CFG_RATE_LIMIT:     rate_limit_q     <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// global pipeline advance: the whole pipe moves unless the skid is full
	// ------------------------------------------------------------------
	logic    pipe_en;
	logic    skid_v_q;
	logic    out_valid_q;
	result_t out_q;
	result_t skid_q;
	result_t res;
	logic    push;

	assign pipe_en  = !skid_v_q;
	assign in_ready = pipe_en;

	// ------------------------------------------------------------------
	// s1..s4: displacement, magnitude, squares, sum of squares
	// ------------------------------------------------------------------
	logic [2:0][31:0]      end_pos;
	logic [2:0][MAG_W-1:0] d_s1;
	logic [31:0]           len_s1;
	logic                  slack_s1;
	logic                  v_s1, v_s2, v_s3, v_s4;
	logic [2:0][MAG_W-1:0] mag_s2;
	logic [2:0]            neg_s2;
	logic [31:0]           len_s2;
	logic                  slack_s2;
	logic [2:0][RAD_W-1:0] sq_s3;
	sqrt_side_t            side_s3;
	logic [RAD_W-1:0]      rad_s4;
	sqrt_side_t            side_s4;

	assign end_pos = {end_z, end_y, end_x};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (pipe_en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			for (int i = 0; i < 3; i++) begin
				// d = anchor - end, 33 bits signed
				d_s1[i]   <= {anchor_q[i][31], anchor_q[i]} - {end_pos[i][31], end_pos[i]};
				neg_s2[i] <= d_s1[i][MAG_W-1];
				mag_s2[i] <= d_s1[i][MAG_W-1] ? MAG_W'(-d_s1[i]) : d_s1[i];
				sq_s3[i]  <= mag_s2[i] * mag_s2[i];
			end
			len_s1        <= line_length;
			slack_s1      <= slack_mode;
			len_s2        <= len_s1;
			slack_s2      <= slack_s1;
			side_s3.mag   <= mag_s2;
			side_s3.neg   <= neg_s2;
			side_s3.len   <= len_s2;
			side_s3.slack <= slack_s2;
			rad_s4        <= sq_s3[0] + sq_s3[1] + sq_s3[2];
			side_s4       <= side_s3;
		end
	end

	// ------------------------------------------------------------------
	// norm of the displacement
	// ------------------------------------------------------------------
	logic              v_sq;
	logic [ROOT_W-1:0] norm_sq;
	sqrt_side_t        side_sq;

	stfr_sqrt_pipe u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (pipe_en),
		.in_v     (v_s4),
		.rad      (rad_s4),
		.in_side  (side_s4),
		.out_v    (v_sq),
		.root     (norm_sq),
		.out_side (side_sq)
	);

	// ------------------------------------------------------------------
	// s5..s8: elongation, tension, slack command, divider setup
	// ------------------------------------------------------------------
	logic                     v_s5, v_s6, v_s7, v_s8;
	logic [ROOT_W-1:0]        elong_s5;
	logic [34:0]              cmd_raw_s5;
	logic [ROOT_W-1:0]        norm_s5, norm_s6, norm_s7, norm_s8;
	sqrt_side_t               side_s5, side_s6, side_s7;
	logic [31+ROOT_W:0]       prod_s6;
	logic [34:0]              cmd_s6;
	logic [31:0]              ten_s7;
	logic [34:0]              byp_s7;
	logic [64-FRAC_BITS:0]    ten_sh;
	logic [2:0][FNUM_W-1:0]   num_s8;
	fdiv_side_t               fside_s8;
	logic                     err_neg_s8;
	logic [31:0]              err_mag_s8;
	logic                     use_div_s8;
	logic [34:0]              byp_mag_s8;
	logic                     byp_neg_s8;
	logic                     target_pos;

	// tension = stiffness * elongation, dropped fraction, capped at 32 bits
	assign ten_sh     = prod_s6[64:FRAC_BITS];
	assign target_pos = !tension_target_q[31] && (tension_target_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (pipe_en) begin
			v_s5 <= v_sq;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			// s5
			elong_s5   <= (norm_sq >= {1'b0, side_sq.len}) ?
				ROOT_W'(norm_sq - {1'b0, side_sq.len}) : '0;
			cmd_raw_s5 <= {{3{slack_offset_q[31]}}, slack_offset_q} + {2'b00, norm_sq};
			norm_s5    <= norm_sq;
			side_s5    <= side_sq;
			// s6
			prod_s6    <= stiffness_q * elong_s5;
			cmd_s6     <= ($signed(cmd_raw_s5) > $signed({3'b000, length_limit_q})) ?
				{3'b000, length_limit_q} : cmd_raw_s5;
			norm_s6    <= norm_s5;
			side_s6    <= side_s5;
			// s7
			ten_s7     <= (ten_sh[64-FRAC_BITS:32] != '0) ? 32'hFFFF_FFFF : ten_sh[31:0];
			byp_s7     <= cmd_s6 - {3'b000, side_s6.len};
			norm_s7    <= norm_s6;
			side_s7    <= side_s6;
			// s8: force numerators
			for (int i = 0; i < 3; i++) begin
				num_s8[i] <= side_s7.mag[i] * ten_s7;
			end
			norm_s8       <= norm_s7;
			fside_s8.ten  <= ten_s7;
			fside_s8.zero <= (ten_s7 == '0) || (norm_s7 == '0);
			fside_s8.neg  <= side_s7.neg;
			// s8: tension error for tension tracking
			err_neg_s8 <= ten_s7 > tension_target_q;
			err_mag_s8 <= (ten_s7 > tension_target_q) ? ten_s7 - tension_target_q :
				tension_target_q - ten_s7;
			use_div_s8 <= !side_s7.slack && target_pos && (stiffness_q != '0);
			// slack mode passes its difference around the divider, hold gives zero
			byp_neg_s8 <= side_s7.slack && byp_s7[34];
			byp_mag_s8 <= !side_s7.slack ? '0 : (byp_s7[34] ? 35'(-byp_s7) : byp_s7);
		end
	end

	// ------------------------------------------------------------------
	// force path: divide by norm, saturate, delay to line up with the rate
	// ------------------------------------------------------------------
	logic [2:0][31:0] fq;
	fdiv_side_t       fside_q;
	fout_t            fsat;
	fout_t            fd_s [FORCE_DELAY];

	stfr_force_div u_fdiv (
		.clk      (clk),
		.en       (pipe_en),
		.num      (num_s8),
		.norm     (norm_s8),
		.in_side  (fside_s8),
		.q        (fq),
		.out_side (fside_q)
	);

	always_comb begin
		fsat.ten = fside_q.ten;
		for (int l = 0; l < 3; l++) begin
			if (fside_q.zero) begin
				fsat.frc[l] = '0;
			end else if (fside_q.neg[l]) begin
				fsat.frc[l] = (fq[l] > FORCE_NEG_MAX) ? FORCE_NEG_MAX : 32'(-fq[l]);
			end else begin
				fsat.frc[l] = (fq[l] > FORCE_POS_MAX) ? FORCE_POS_MAX : fq[l];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			fd_s[0] <= fsat;
			for (int j = 1; j < FORCE_DELAY; j++) begin
				fd_s[j] <= fd_s[j-1];
			end
		end
	end

	// ------------------------------------------------------------------
	// rate path: tension error divided by stiffness, one quotient bit per stage
	// ------------------------------------------------------------------
	logic [RDIV_STEPS:1] rv_s;
	rdiv_stage_t         rd_s [1:RDIV_STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_s <= '0;
		end else if (pipe_en) begin
			rv_s <= {rv_s[RDIV_STEPS-1:1], v_s8};
		end
	end

	for (genvar k = 0; k < RDIV_STEPS; k++) begin : g_rdiv
		rdiv_stage_t prev;
		rdiv_stage_t nxt;
		logic [32:0] t;
		logic        ge;

		if (k == 0) begin : g_first
			assign prev = '{
				num:     {err_mag_s8, {FRAC_BITS{1'b0}}},
				rem:     '0,
				q:       '0,
				use_div: use_div_s8,
				err_neg: err_neg_s8,
				byp_mag: byp_mag_s8,
				byp_neg: byp_neg_s8
			};
		end else begin : g_rest
			assign prev = rd_s[k];
		end

		assign t  = {prev.rem, prev.num[RDIV_STEPS-1]};
		assign ge = t >= {1'b0, stiffness_q};

		always_comb begin
			nxt     = prev;
			nxt.num = {prev.num[RDIV_STEPS-2:0], 1'b0};
			nxt.q   = {prev.q[RDIV_STEPS-2:0], ge};
			nxt.rem = ge ? 32'(t - {1'b0, stiffness_q}) : t[31:0];
		end

		always_ff @(posedge clk) begin
			if (pipe_en) begin
				rd_s[k+1] <= nxt;
			end
		end
	end

	// ------------------------------------------------------------------
	// s9..s12: rate gain and saturation
	// ------------------------------------------------------------------
	rdiv_stage_t             rdo;
	logic [RDIV_STEPS-1:0]   dmag;
	logic                    v_s9, v_s10, v_s11, v_s12;
	logic [CLAMP_W-1:0]      mag_s9;
	logic                    neg_s9, neg_s10, neg_s11;
	logic [LO_W+GAIN_W-1:0]  lo_s10;
	logic [HI_W+GAIN_W-1:0]  hi_s10;
	logic [PROD_W-1:0]       prod;
	logic [PROD_W-FRAC_BITS-1:0] prod_sh;
	logic [30:0]             r_s11;
	logic [31:0]             rate_s12;

	assign rdo  = rd_s[RDIV_STEPS];
	assign dmag = rdo.use_div ? rdo.q : RDIV_STEPS'(rdo.byp_mag);
	// sum of the partial products, then drop the fraction
	assign prod    = (PROD_W'(hi_s10) << LO_W) + PROD_W'(lo_s10);
	assign prod_sh = prod[PROD_W-1:FRAC_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
		end else if (pipe_en) begin
			v_s9  <= rv_s[RDIV_STEPS];
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			// a difference this large always ends at the rate limit
			mag_s9  <= dmag[RDIV_STEPS-1] ? '1 : dmag[CLAMP_W-1:0];
			// positive tension error shortens the command
			neg_s9  <= rdo.use_div ? !rdo.err_neg : rdo.byp_neg;
			lo_s10  <= mag_s9[LO_W-1:0] * RATE_GAIN;
			hi_s10  <= mag_s9[CLAMP_W-1:LO_W] * RATE_GAIN;
			neg_s10 <= neg_s9;
			r_s11   <= (prod_sh > (PROD_W-FRAC_BITS)'(rate_limit_q)) ?
				rate_limit_q : prod_sh[30:0];
			neg_s11 <= neg_s10;
			rate_s12 <= neg_s11 ? 32'(-{1'b0, r_s11}) : {1'b0, r_s11};
		end
	end

	// ------------------------------------------------------------------
	// output register with a skid entry behind it
	// ------------------------------------------------------------------
	assign push     = pipe_en && v_s12;
	assign res.frc  = fd_s[FORCE_DELAY-1].frc;
	assign res.ten  = fd_s[FORCE_DELAY-1].ten;
	assign res.rate = rate_s12;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_v_q    <= 1'b0;
		end else if (out_ready || !out_valid_q) begin
			if (skid_v_q) begin
				out_valid_q <= 1'b1;
				skid_v_q    <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready || !out_valid_q) begin
			out_q <= skid_v_q ? skid_q : res;
		end else if (push) begin
			skid_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign force_x     = out_q.frc[0];
	assign force_y     = out_q.frc[1];
	assign force_z     = out_q.frc[2];
	assign tension     = out_q.ten;
	assign length_rate = out_q.rate;

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	`STFR_ASSERT_IMPLY(a_skid_behind_out, skid_v_q, out_valid_q)
	`STFR_ASSERT_NEXT(a_skid_holds, skid_v_q && !out_ready, skid_v_q && out_valid_q)
	`STFR_ASSERT_IMPLY(a_rate_pos_bound, out_valid && !length_rate[31],
		length_rate[30:0] <= rate_limit_q)
	`STFR_ASSERT_IMPLY(a_rate_neg_bound, out_valid && length_rate[31],
		(~length_rate + 32'd1) <= {1'b0, rate_limit_q})
	`STFR_ASSERT_IMPLY(a_no_force_when_slack, out_valid && tension == '0,
		force_x == '0 && force_y == '0 && force_z == '0)

endmodule

>>> src/stfr_sqrt_pipe.sv
// pipelined floor square root, one result bit per stage
module stfr_sqrt_pipe import stfr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_v,
	input  logic [RAD_W-1:0]  rad,
	input  sqrt_side_t        in_side,
	output logic              out_v,
	output logic [ROOT_W-1:0] root,
	output sqrt_side_t        out_side
);

	typedef struct packed {
		logic [RAD_W-1:0]  rad;
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
		sqrt_side_t        side;
	} sqrt_stage_t;

	logic [SQRT_STEPS:1] v_s;
	sqrt_stage_t         stg_s [1:SQRT_STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[SQRT_STEPS-1:1], in_v};
		end
	end

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
		sqrt_stage_t        prev;
		logic [REM_W+1:0]   cur;
		logic [REM_W+1:0]   trial;

		if (k == 0) begin : g_first
			assign prev = '{rad: rad, rem: '0, root: '0, side: in_side};
		end else begin : g_rest
			assign prev = stg_s[k];
		end

		// bring down the next pair of radicand bits
		assign cur   = {prev.rem, prev.rad[RAD_W-1-2*k -: 2]};
		assign trial = (REM_W+2)'({prev.root, 2'b01});

		always_ff @(posedge clk) begin
			if (en) begin
				stg_s[k+1].rad  <= prev.rad;
				stg_s[k+1].side <= prev.side;
				if (cur >= trial) begin
					stg_s[k+1].rem  <= REM_W'(cur - trial);
					stg_s[k+1].root <= {prev.root[ROOT_W-2:0], 1'b1};
				end else begin
					stg_s[k+1].rem  <= REM_W'(cur);
					stg_s[k+1].root <= {prev.root[ROOT_W-2:0], 1'b0};
				end
			end
		end
	end

	assign out_v    = v_s[SQRT_STEPS];
	assign root     = stg_s[SQRT_STEPS].root;
	assign out_side = stg_s[SQRT_STEPS].side;

endmodule

>>> src/stfr_force_div.sv
// three-lane pipelined restoring divider for the force components
module stfr_force_div import stfr_pkg::*; (
	input  logic                   clk,
	input  logic                   en,
	input  logic [2:0][FNUM_W-1:0] num,
	input  logic [ROOT_W-1:0]      norm,
	input  fdiv_side_t             in_side,
	output logic [2:0][31:0]       q,
	output fdiv_side_t             out_side
);

	typedef struct packed {
		logic [2:0][31:0]       lo;
		logic [2:0][ROOT_W-1:0] rem;
		logic [2:0][31:0]       q;
		logic [ROOT_W-1:0]      norm;
		fdiv_side_t             side;
	} fdiv_stage_t;

	fdiv_stage_t stg_s [1:FDIV_STEPS];

	for (genvar k = 0; k < FDIV_STEPS; k++) begin : g_step
		fdiv_stage_t prev;
		fdiv_stage_t nxt;

		if (k == 0) begin : g_first
			// quotient fits 32 bits, so the upper numerator part is below norm
			assign prev = '{
				lo:   {num[2][31:0], num[1][31:0], num[0][31:0]},
				rem:  {num[2][FNUM_W-1:32], num[1][FNUM_W-1:32], num[0][FNUM_W-1:32]},
				q:    '0,
				norm: norm,
				side: in_side
			};
		end else begin : g_rest
			assign prev = stg_s[k];
		end

		always_comb begin
			logic [ROOT_W:0] t;
			logic            ge;
			nxt = prev;
			for (int l = 0; l < 3; l++) begin
				t  = {prev.rem[l], prev.lo[l][31]};
				ge = (t >= {1'b0, prev.norm});
				nxt.rem[l] = ge ? ROOT_W'(t - {1'b0, prev.norm}) : t[ROOT_W-1:0];
				nxt.q[l]   = {prev.q[l][30:0], ge};
				nxt.lo[l]  = {prev.lo[l][30:0], 1'b0};
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				stg_s[k+1] <= nxt;
			end
		end
	end

	assign q        = stg_s[FDIV_STEPS].q;
	assign out_side = stg_s[FDIV_STEPS].side;

endmodule

>>> tb/spring_tether_force_and_rate_unit_tb.sv
// self-checking testbench for the spring tether force and rate unit
`timescale 1ns / 100ps

module spring_tether_force_and_rate_unit_tb import stfr_pkg::*; ();

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic [31:0]        len;
		logic               slack;
	} end_req_t;

	typedef struct {
		logic signed [31:0] fx;
		logic signed [31:0] fy;
		logic signed [31:0] fz;
		logic [31:0]        ten;
		logic signed [31:0] rate;
	} tether_res_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_wr_en;
	logic [2:0]         cfg_index;
	logic [31:0]        cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic signed [31:0] end_x;
	logic signed [31:0] end_y;
	logic signed [31:0] end_z;
	logic [31:0]        line_length;
	logic               slack_mode;
	logic               out_valid;
	logic               out_ready;
	logic signed [31:0] force_x;
	logic signed [31:0] force_y;
	logic signed [31:0] force_z;
	logic [31:0]        tension;
	logic signed [31:0] length_rate;

	// local copy of the register file, kept in step with every write
	logic signed [31:0] anc_x, anc_y, anc_z, ten_tgt, slk_off;
	logic [31:0]        stiff, len_lim;
	logic [30:0]        rate_lim;

	end_req_t    pending_reqs[$];
	tether_res_t expected_res[$];
	int          fail_cnt;
	bit          no_gaps;
	int          in_gap;
	int          out_stall;

	spring_tether_force_and_rate_unit uut (.*);

	always #4 clk = ~clk;

	// hard stop well past the slowest legal run
	initial begin
		#8000000;
		$display("FAILED: results differ");
		$finish;
	end

	// gap lengths: mostly none or short, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// floor square root of a 66-bit sum of squares, two bits per step
	function automatic logic [32:0] sqrt66(logic [65:0] v);
		logic [32:0] root;
		logic [67:0] rem;
		logic [67:0] trial;
		root = '0;
		rem = '0;
		for (int i = 32; i >= 0; i--) begin
			rem = (rem << 2) | 68'(v[2*i +: 2]);
			trial = (68'(root) << 2) | 68'd1;
			if (rem >= trial) begin
				rem = rem - trial;
				root = {root[31:0], 1'b1};
			end else begin
				root = {root[31:0], 1'b0};
			end
		end
		return root;
	endfunction

	// distance from the line end to the anchor under the current registers
	function automatic logic [32:0] anchor_dist(end_req_t r, output logic signed [32:0] d[3]);
		logic [32:0] m;
		logic [65:0] sum;
		d[0] = 33'(anc_x) - 33'(r.x);
		d[1] = 33'(anc_y) - 33'(r.y);
		d[2] = 33'(anc_z) - 33'(r.z);
		sum = '0;
		for (int i = 0; i < 3; i++) begin
			m = d[i][32] ? 33'(-d[i]) : 33'(d[i]);
			sum = sum + 66'(m) * 66'(m);
		end
		return sqrt66(sum);
	endfunction

	// force along one axis, magnitude truncated toward zero and saturated
	function automatic logic signed [31:0] axis_force(logic signed [32:0] d, logic [31:0] ten,
			logic [32:0] norm);
		logic [32:0] m;
		logic [64:0] q;
		if (ten == 0 || norm == 0)
			return '0;
		m = d[32] ? 33'(-d) : 33'(d);
		q = (65'(m) * 65'(ten)) / 65'(norm);
		if (d[32]) begin
			if (q > 65'h8000_0000)
				q = 65'h8000_0000;
			return 32'(-q);
		end
		if (q > 65'h7FFF_FFFF)
			q = 65'h7FFF_FFFF;
		return q[31:0];
	endfunction

	// spring force, tension and commanded length rate for one request
	function automatic tether_res_t tether_predict(end_req_t r);
		tether_res_t res;
		logic signed [32:0] d[3];
		logic [32:0]  norm, elong;
		logic [64:0]  prod;
		logic [31:0]  ten;
		longint       cmd, err, diff;
		logic [63:0]  q, ad;
		logic [127:0] gp;
		logic [31:0]  rmag;
		norm = anchor_dist(r, d);
		elong = (norm < 33'(r.len)) ? '0 : norm - 33'(r.len);
		prod = (65'(stiff) * 65'(elong)) >> FRAC_BITS;
		ten = (prod > 65'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0];
		res.fx = axis_force(d[0], ten, norm);
		res.fy = axis_force(d[1], ten, norm);
		res.fz = axis_force(d[2], ten, norm);
		res.ten = ten;
		if (r.slack) begin
			cmd = longint'(slk_off) + longint'(norm);
			if (cmd > longint'(len_lim))
				cmd = longint'(len_lim);
		end else if (ten_tgt <= 0 || stiff == 0) begin
			// hold mode, or no spring to correct with
			cmd = longint'(r.len);
		end else begin
			err = longint'(ten_tgt) - longint'(ten);
			q = (64'(err < 0 ? -err : err) << FRAC_BITS) / 64'(stiff);
			cmd = (err < 0) ? longint'(r.len) + longint'(q) : longint'(r.len) - longint'(q);
		end
		diff = cmd - longint'(r.len);
		ad = 64'(diff < 0 ? -diff : diff);
		gp = (128'(ad) * 128'(RATE_GAIN)) >> FRAC_BITS;
		rmag = (gp > 128'(rate_lim)) ? 32'(rate_lim) : gp[31:0];
		res.rate = (diff < 0) ? -rmag : rmag;
		return res;
	endfunction

	// driver: presents queued requests with random gaps, predicts on accept
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				expected_res.push_back(tether_predict('{end_x, end_y, end_z, line_length,
					slack_mode}));
			if (!in_valid || in_ready) begin
				if (in_gap > 0) begin
					in_gap <= in_gap - 1;
					in_valid <= 1'b0;
				end else if (pending_reqs.size() > 0) begin
					end_req_t nr;
					nr = pending_reqs.pop_front();
					end_x <= nr.x;
					end_y <= nr.y;
					end_z <= nr.z;
					line_length <= nr.len;
					slack_mode <= nr.slack;
					in_valid <= 1'b1;
					in_gap <= pick_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: random backpressure, field-by-field check against oldest expectation
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_res.size() == 0) begin
					$error("result with no expectation waiting");
					fail_cnt++;
				end else begin
					tether_res_t e;
					e = expected_res.pop_front();
					if (force_x !== e.fx) begin
						$error("force_x expected %0d got %0d", e.fx, force_x);
						fail_cnt++;
					end
					if (force_y !== e.fy) begin
						$error("force_y expected %0d got %0d", e.fy, force_y);
						fail_cnt++;
					end
					if (force_z !== e.fz) begin
						$error("force_z expected %0d got %0d", e.fz, force_z);
						fail_cnt++;
					end
					if (tension !== e.ten) begin
						$error("tension expected %0d got %0d", e.ten, tension);
						fail_cnt++;
					end
					if (length_rate !== e.rate) begin
						$error("length_rate expected %0d got %0d", e.rate, length_rate);
						fail_cnt++;
					end
				end
			end
			if (out_stall > 0) begin
				out_stall <= out_stall - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				out_stall <= pick_gap();
			end
		end
	end

	// register write: drive at this edge, taken at the next
	task automatic reg_write(cfg_reg_t idx, logic [31:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			CFG_ANCHOR_X:       anc_x = val;
			CFG_ANCHOR_Y:       anc_y = val;
			CFG_ANCHOR_Z:       anc_z = val;
			CFG_STIFFNESS:      stiff = val;
			CFG_TENSION_TARGET: ten_tgt = val;
			CFG_SLACK_OFFSET:   slk_off = val;
			CFG_LENGTH_LIMIT:   len_lim = val;
			CFG_RATE_LIMIT:     rate_lim = val[30:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// register value: extremes on phases 1 and 2, mixed picks elsewhere
	function automatic logic [31:0] reg_pick(int phase, cfg_reg_t idx);
		int r;
		r = $urandom_range(0, 5);
		if (phase == 1)
			r = 0;
		else if (phase == 2)
			r = 1;
		case (idx)
			CFG_STIFFNESS:
				case (r)
					0: return 32'hFFFF_FFFF;
					1: return 32'd0;
					2: return 32'd1;
					3: return 32'd65536;
					4: return $urandom_range(1, 32'h0010_0000);
					default: return $urandom;
				endcase
			CFG_LENGTH_LIMIT, CFG_RATE_LIMIT:
				case (r)
					0: return 32'hFFFF_FFFF;
					1: return 32'd0;
					2: return $urandom_range(1, 32'h0004_0000);
					3: return {1'b0, 31'h7FFF_FFFF};
					default: return $urandom;
				endcase
			default:
				case (r)
					0: return 32'h7FFF_FFFF;
					1: return 32'h8000_0000;
					2: return 32'd0;
					3: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
					4: return $urandom_range(1, 32'h0040_0000);
					default: return $urandom;
				endcase
		endcase
	endfunction

	// one coordinate: near the anchor, fully random, or at an extreme
	function automatic logic signed [31:0] coord_pick(logic signed [31:0] anc);
		int r;
		r = $urandom_range(0, 9);
		if (r < 5)
			return anc + ($urandom_range(0, 32'h0008_0000) - 32'h0004_0000);
		if (r < 8)
			return $urandom;
		return (r == 8) ? 32'h7FFF_FFFF : 32'h8000_0000;
	endfunction

	// a well-formed request: line length mostly set near the actual distance, else random or extreme
	function automatic end_req_t req_pick();
		end_req_t rq;
		logic signed [32:0] d[3];
		logic [32:0] norm;
		int r;
		rq.x = coord_pick(anc_x);
		rq.y = coord_pick(anc_y);
		rq.z = coord_pick(anc_z);
		rq.slack = 1'($urandom_range(0, 1));
		norm = anchor_dist(rq, d);
		r = $urandom_range(0, 9);
		if (r < 6) begin
			rq.len = 32'(norm) - $urandom_range(0, 32'h0002_0000) + 32'h0000_8000;
			if (norm > 33'hFFFF_FFFF)
				rq.len = 32'hFFFF_FFFF - $urandom_range(0, 255);
		end else if (r < 9) begin
			rq.len = $urandom;
		end else begin
			rq.len = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
		end
		return rq;
	endfunction

	initial begin
		end_req_t rq;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = CFG_ANCHOR_X;
		cfg_data = '0;
		in_valid = 1'b0;
		end_x = '0;
		end_y = '0;
		end_z = '0;
		line_length = '0;
		slack_mode = 1'b0;
		out_ready = 1'b0;
		fail_cnt = 0;
		no_gaps = 1'b0;
		in_gap = 0;
		out_stall = 0;
		// register copy starts at the reset values
		anc_x = 0;
		anc_y = 0;
		anc_z = 0;
		stiff = 32'd65536;
		ten_tgt = 0;
		slk_off = 0;
		len_lim = 32'hFFFF_FFFF;
		rate_lim = 31'd65536;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int phase = 0; phase < 9; phase++) begin
			// reconfigure only while idle: nothing queued, in flight or expected
			if (phase > 0) begin
				for (int i = 0; i < 8; i++)
					reg_write(cfg_reg_t'(i), reg_pick(phase, cfg_reg_t'(i)));
				cfg_wr_en <= 1'b0;
				@(posedge clk);
			end
			no_gaps = (phase == 3 || phase == 6);

			if (phase == 0) begin
				// directed: distance zero, extremes of position and length, both modes
				pending_reqs.push_back('{32'sd0, 32'sd0, 32'sd0, 32'd0, 1'b0});
				pending_reqs.push_back('{32'sd0, 32'sd0, 32'sd0, 32'd0, 1'b1});
				pending_reqs.push_back('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
					32'd0, 1'b0});
				pending_reqs.push_back('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
					32'd0, 1'b1});
				pending_reqs.push_back('{32'h8000_0000, 32'h7FFF_FFFF, 32'sd0,
					32'hFFFF_FFFF, 1'b0});
				pending_reqs.push_back('{32'h0001_0000, 32'sd0, 32'sd0, 32'h0000_8000, 1'b0});
				pending_reqs.push_back('{-32'sh0003_0000, 32'sh0004_0000, 32'sd0,
					32'h0002_0000, 1'b1});
				pending_reqs.push_back('{32'sd0, 32'sd0, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1});
				pending_reqs.push_back('{32'sd1, -32'sd1, 32'sd1, 32'd1, 1'b0});
				pending_reqs.push_back('{32'h7FFF_FFFF, 32'sd0, 32'sd0, 32'h7FFF_FFFF, 1'b0});
			end else if (phase == 1) begin
				// max stiffness, max anchors, positive target: saturating tension and rate
				pending_reqs.push_back('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
					32'd0, 1'b0});
				pending_reqs.push_back('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
					32'd0, 1'b1});
				pending_reqs.push_back('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
					32'd5, 1'b0});
				pending_reqs.push_back('{32'h7FFF_FFFE, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
					32'd0, 1'b0});
			end else if (phase == 2) begin
				// zero stiffness and zero rate bound
				pending_reqs.push_back('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
					32'd0, 1'b0});
				pending_reqs.push_back('{32'h7FFF_FFFF, 32'sd0, 32'sd0, 32'd0, 1'b1});
				pending_reqs.push_back('{32'sd0, 32'sd0, 32'sd0, 32'hFFFF_FFFF, 1'b0});
			end

			for (int n = 0; n < 160; n++) begin
				if ($urandom_range(0, 9) == 0)
					rq = '{$urandom, $urandom, $urandom, $urandom, 1'($urandom)};
				else
					rq = req_pick();
				pending_reqs.push_back(rq);
			end

			// drain: all requests taken and every result back, then the pipe latency
			while (pending_reqs.size() > 0 || in_valid || expected_res.size() > 0)
				@(posedge clk);
			repeat (120) @(posedge clk);
		end

		if (fail_cnt == 0 && expected_res.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
